>>> rtl/core/hpq_pkg.sv
`default_nettype none

package hpq_pkg;

  // Queue depth; one cell per entry.
  localparam int CAPACITY = 256;
  localparam int VALUE_W  = 32;
  // Fill count runs 0..CAPACITY inclusive.
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // Stream payload widths (fields packed from bit 0, padded to bytes).
  localparam int IN_TDATA_W  = VALUE_W;
  localparam int OUT_FIELD_W = VALUE_W + CNT_W;
  localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;
  localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_FIELD_W;

  typedef enum logic {
    CMD_PUSH = 1'b0,
    CMD_POP  = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    ST_PUSH_DONE = 2'd0,
    ST_POP_DONE  = 2'd1,
    ST_FULL      = 2'd2,
    ST_EMPTY     = 2'd3
  } status_e;

  // Broadcast to every cell for the current transaction.
  typedef struct packed {
    logic                      push;
    logic                      pop;
    logic signed [VALUE_W-1:0] value;
  } cell_ctl_t;

  // What a cell shows its neighbours.
  typedef struct packed {
    logic                      valid;
    logic                      lt;     // incoming value goes at or before this cell
    logic signed [VALUE_W-1:0] value;
  } cell_out_t;

endpackage

`default_nettype wire

>>> rtl/core/hpq_cell.sv
`default_nettype none

module hpq_cell
  import hpq_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire cell_ctl_t ctl_i,
  input  wire cell_out_t prev_i,  // neighbour nearer the head
  input  wire cell_out_t next_i,  // neighbour nearer the tail
  output cell_out_t      cell_o
);

  logic                      valid_q, valid_d;
  logic signed [VALUE_W-1:0] value_q, value_d;
  logic                      lt;

  // Empty cells always compare as lt; otherwise strict compare.
  assign lt = !valid_q || (ctl_i.value < value_q);

  always_comb begin
    valid_d = valid_q;
    value_d = value_q;
    if (ctl_i.push && lt) begin
      if (prev_i.lt) begin
        // shift towards the tail to make room
        valid_d = prev_i.valid;
        value_d = prev_i.value;
      end else begin
        valid_d = 1'b1;
        value_d = ctl_i.value;
      end
    end else if (ctl_i.pop) begin
      valid_d = next_i.valid;
      value_d = next_i.value;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign cell_o.valid = valid_q;
  assign cell_o.lt    = lt;
  assign cell_o.value = value_q;

endmodule

`default_nettype wire

>>> rtl/core/binary_min_heap_queue_core.sv
`default_nettype none

// Min-priority queue of signed 32-bit values.
//
// Input stream (s_axis): tuser selects the command (0 push, 1 pop), tdata
// carries the value to push (ignored on a pop). Output stream (m_axis): one
// transaction per input transaction, in order; tuser is the status (push done,
// pop done, push dropped as full, pop on empty), tdata the popped value (zero
// unless a pop succeeded) and the entry count after the command.
//
// Storage is a row of CAPACITY identical cells kept sorted ascending; the
// head cell holds the minimum. A push compares against every cell at once and
// the cells past the insertion point each take their neighbour's entry; a pop
// moves every entry one cell towards the head. Either is one compare-and-shift
// step of the cell row, so a command is accepted per cycle while the output
// register is free or being drained; its result is in the output register
// from the following cycle.
//
// Reset empties the queue (cell valid bits and the fill count clear at once;
// no sweep). If the receiver stalls, the result is held in the output
// register and s_axis_tready_o drops until it is taken; a command is still
// accepted in the same cycle the held result drains.
module binary_min_heap_queue_core
  import hpq_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  // command in
  input  wire logic                   s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata_i,   // [31:0] value
  input  wire logic                   s_axis_tuser_i,   // [0] command
  // result out
  output logic                        m_axis_tvalid_o,
  input  wire logic                   m_axis_tready_i,
  output logic [OUT_TDATA_W-1:0]      m_axis_tdata_o,   // [31:0] popped_value,
                                                        // [40:32] entry_count, rest zero
  output logic [1:0]                  m_axis_tuser_o    // [1:0] status
);

  cell_ctl_t                 ctl;
  cell_out_t                 cells [CAPACITY];
  logic [CAPACITY-1:0]       valid_vec;

  logic [CNT_W-1:0]          count_q, count_d;
  logic                      out_valid_q;
  logic signed [VALUE_W-1:0] out_popped_q, out_popped_d;
  status_e                   out_status_q, out_status_d;
  logic [CNT_W-1:0]          out_count_q;

  logic accept, is_pop, full, empty;

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign is_pop          = (s_axis_tuser_i == CMD_POP);
  assign full            = (count_q == CNT_W'(CAPACITY));
  assign empty           = (count_q == '0);

  // Command decode
  always_comb begin
    ctl.push     = 1'b0;
    ctl.pop      = 1'b0;
    ctl.value    = s_axis_tdata_i;
    count_d      = count_q;
    out_popped_d = '0;
    out_status_d = ST_PUSH_DONE;
    if (is_pop) begin
      if (empty) begin
        out_status_d = ST_EMPTY;
      end else begin
        ctl.pop      = accept;
        count_d      = count_q - 1'b1;
        out_popped_d = cells[0].value;
        out_status_d = ST_POP_DONE;
      end
    end else begin
      if (full) begin
        out_status_d = ST_FULL;
      end else begin
        ctl.push     = accept;
        count_d      = count_q + 1'b1;
        out_status_d = ST_PUSH_DONE;
      end
    end
  end

  // Cell row: head at index 0
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    cell_out_t prev_s, next_s;

    if (i == 0) begin : g_head
      assign prev_s = '{valid: 1'b1, lt: 1'b0, value: '0};
    end else begin : g_mid
      assign prev_s = cells[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign next_s = '{valid: 1'b0, lt: 1'b1, value: '0};
    end else begin : g_body
      assign next_s = cells[i+1];
    end

    hpq_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (ctl),
      .prev_i (prev_s),
      .next_i (next_s),
      .cell_o (cells[i])
    );

    assign valid_vec[i] = cells[i].valid;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q <= count_d;
      end
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_popped_q <= out_popped_d;
      out_status_q <= out_status_d;
      out_count_q  <= count_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{OUT_PAD_W{1'b0}}, out_count_q, out_popped_q};
  assign m_axis_tuser_o  = out_status_q;

  // Occupied cells match the fill count
  a_count_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_vec) == int'(count_q))
    else $error("cell valid bits disagree with fill count");

  // Occupied cells form a contiguous run from the head
  a_contiguous: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_vec & CAPACITY'(valid_vec + 1'b1)) == '0)
    else $error("hole in occupied cells");

  // Popped value never exceeds the new head
  a_pop_ordered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_status_q == ST_POP_DONE && valid_vec[0])
      |-> (out_popped_q <= cells[0].value))
    else $error("pop returned a value above the new minimum");

endmodule

`default_nettype wire
